// ----- src/awc_pkg.sv -----
`default_nettype none
package awc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGES        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // vector components: 1/256 m/s with 16 fraction bits, headroom for cordic gain
  localparam int XW = 36;
  // residual angle of the rotation pass
  localparam int ZW = 33;

  localparam logic [15:0] INV_GAIN  = 16'd39797;
  localparam logic [14:0] SPEED_MAX = 15'd32767;

  localparam logic [7:0] CFG_DIRECTION_SOURCE = 8'd0;
  localparam logic [7:0] CFG_SPEED_SOURCE     = 8'd1;

  // index of the last stage of the side-band delay line
  localparam int LAST = 2 * STAGES + 4;

  typedef struct packed {
    logic signed [14:0] vn;
    logic signed [14:0] ve;
    logic signed [15:0] yaw;
    logic signed [15:0] given_heading;
    logic        [14:0] given_speed;
  } side_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/apparent_wind_calculator_unit.sv -----
`default_nettype none
// throughput: one transaction per cycle, busy is never raised; one register per cordic step
// sets the depth, first the rotation pipeline and then the vectoring pipeline
// reset: synchronous active-low rst_n clears the valid pipeline, the strobe and both
// mode registers (computed direction and speed); data registers are not reset
module apparent_wind_calculator_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [13:0] in_true_wind_speed,
  input  wire logic        [15:0] in_true_wind_heading,
  input  wire logic signed [14:0] in_velocity_north,
  input  wire logic signed [14:0] in_velocity_east,
  input  wire logic signed [15:0] in_vehicle_yaw,
  input  wire logic signed [15:0] in_given_apparent_heading,
  input  wire logic        [14:0] in_given_apparent_speed,
  output logic                    out_strobe,
  output logic signed [15:0]      out_apparent_heading,
  output logic        [14:0]      out_apparent_speed,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [7:0]  cfg_index,
  input  wire logic        [7:0]  cfg_data
);

  localparam int S = awc_pkg::STAGES;
  localparam int XW = awc_pkg::XW;
  localparam int ZW = awc_pkg::ZW;
  localparam int LAST = awc_pkg::LAST;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic dir_src_r;
  logic spd_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_src_r <= 1'b0;
      spd_src_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == awc_pkg::CFG_DIRECTION_SOURCE) dir_src_r <= cfg_data[0];
      if (cfg_index == awc_pkg::CFG_SPEED_SOURCE)     spd_src_r <= cfg_data[0];
    end
  end

  // valid bits and side-band fields, entry j lines up with pipeline stage j+1
  logic            valid_r [LAST+1];
  awc_pkg::side_t  side_r  [LAST+1];
  awc_pkg::side_t  side_nxt;

  assign side_nxt = '{vn: in_velocity_north, ve: in_velocity_east, yaw: in_vehicle_yaw,
                      given_heading: in_given_apparent_heading,
                      given_speed: in_given_apparent_speed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= LAST; j++) valid_r[j] <= 1'b0;
    end else begin
      valid_r[0] <= start;
      for (int j = 1; j <= LAST; j++) valid_r[j] <= valid_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int j = 1; j <= LAST; j++) side_r[j] <= side_r[j-1];
  end

  // stage 1: speed times 1/K
  logic [29:0] prod_r;
  logic [15:0] hdg_r;

  always_ff @(posedge clk) begin
    prod_r <= 30'(in_true_wind_speed) * 30'(awc_pkg::INV_GAIN);
    hdg_r  <= in_true_wind_heading;
  end

  // stage 2: fold the heading into plus or minus a quarter turn
  logic signed [XW-1:0] prex_r;
  logic signed [ZW-1:0] prez_r;
  logic signed [XW-1:0] xp;
  logic signed [ZW-1:0] zx;

  assign xp = $signed({{(XW-30){1'b0}}, prod_r});
  assign zx = $signed({hdg_r[15], hdg_r, 16'b0});

  always_ff @(posedge clk) begin
    if (zx > $signed(ZW'(34'sh040000000))) begin
      prex_r <= -xp;
      prez_r <= zx - $signed(ZW'(34'sh080000000));
    end else if (zx < -$signed(ZW'(34'sh040000000))) begin
      prex_r <= -xp;
      prez_r <= zx + $signed(ZW'(34'sh080000000));
    end else begin
      prex_r <= xp;
      prez_r <= zx;
    end
  end

  logic signed [XW-1:0] rot_x;
  logic signed [XW-1:0] rot_y;

  awc_rotate u_rotate (
    .clk   (clk),
    .x_in  (prex_r),
    .z_in  (prez_r),
    .x_out (rot_x),
    .y_out (rot_y)
  );

  // add the vehicle velocity
  logic signed [XW-1:0] ax_r;
  logic signed [XW-1:0] ay_r;
  awc_pkg::side_t       side_add;

  assign side_add = side_r[S+1];

  always_ff @(posedge clk) begin
    ax_r <= rot_x + $signed({{(XW-31){side_add.vn[14]}}, side_add.vn, 16'b0});
    ay_r <= rot_y + $signed({{(XW-31){side_add.ve[14]}}, side_add.ve, 16'b0});
  end

  // bring x into the right half plane before vectoring
  logic signed [XW-1:0] vx_r;
  logic signed [XW-1:0] vy_r;
  logic        [31:0]   vacc_r;
  logic                 zero_r [S+1];

  always_ff @(posedge clk) begin
    zero_r[0] <= (ax_r == '0) && (ay_r == '0);
    for (int j = 1; j <= S; j++) zero_r[j] <= zero_r[j-1];
    if (ax_r[XW-1]) begin
      vx_r   <= -ax_r;
      vy_r   <= -ay_r;
      vacc_r <= 32'h80000000;
    end else begin
      vx_r   <= ax_r;
      vy_r   <= ay_r;
      vacc_r <= 32'h00000000;
    end
  end

  logic signed [XW-1:0] vec_x;
  logic        [31:0]   vec_acc;

  awc_vector u_vector (
    .clk     (clk),
    .x_in    (vx_r),
    .y_in    (vy_r),
    .acc_in  (vacc_r),
    .x_out   (vec_x),
    .acc_out (vec_acc)
  );

  // magnitude partial products and the relative heading
  logic [XW-1:0]  xc;
  logic [31:0]    acc_rnd;
  logic [15:0]    ang16;
  logic [15:0]    dir16;
  logic [33:0]    pl_r;
  logic [33:0]    ph_r;
  logic [15:0]    head_r;
  awc_pkg::side_t side_pp;

  assign side_pp = side_r[2*S+3];
  assign xc      = vec_x[XW-1] ? '0 : vec_x;
  assign acc_rnd = vec_acc + 32'h00008000;
  assign ang16   = zero_r[S] ? 16'd0 : acc_rnd[31:16];
  assign dir16   = dir_src_r ? side_pp.given_heading : ang16;

  always_ff @(posedge clk) begin
    pl_r   <= 34'(xc[17:0]) * 34'(awc_pkg::INV_GAIN);
    ph_r   <= 34'(xc[XW-1:18]) * 34'(awc_pkg::INV_GAIN);
    head_r <= dir16 - side_pp.yaw;
  end

  // final sum, rounding and saturation
  logic [52:0] mag_sum;
  logic [20:0] mag;
  logic [14:0] spd_calc;

  assign mag_sum  = {1'b0, ph_r, 18'b0} + 53'(pl_r) + 53'h80000000;
  assign mag      = mag_sum[52:32];
  assign spd_calc = (mag > 21'(awc_pkg::SPEED_MAX)) ? awc_pkg::SPEED_MAX : mag[14:0];

  logic              out_strobe_r;
  logic signed [15:0] out_head_r;
  logic [14:0]       out_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= valid_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    out_head_r  <= head_r;
    out_speed_r <= spd_src_r ? side_r[LAST].given_speed : spd_calc;
  end

  assign out_strobe           = out_strobe_r;
  assign out_apparent_heading = out_head_r;
  assign out_apparent_speed   = out_speed_r;

endmodule
`default_nettype wire

// ----- src/awc_rotate.sv -----
`default_nettype none
module awc_rotate (
  input  wire logic                          clk,
  input  wire logic signed [awc_pkg::XW-1:0] x_in,
  input  wire logic signed [awc_pkg::ZW-1:0] z_in,
  output logic signed [awc_pkg::XW-1:0]      x_out,
  output logic signed [awc_pkg::XW-1:0]      y_out
);

  logic signed [awc_pkg::XW-1:0] x_r [awc_pkg::STAGES];
  logic signed [awc_pkg::XW-1:0] y_r [awc_pkg::STAGES];
  logic signed [awc_pkg::ZW-1:0] z_r [awc_pkg::STAGES];

  for (genvar i = 0; i < awc_pkg::STAGES; i++) begin : g_stage
    logic signed [awc_pkg::XW-1:0] px;
    logic signed [awc_pkg::XW-1:0] py;
    logic signed [awc_pkg::ZW-1:0] pz;
    logic signed [awc_pkg::ZW-1:0] at;
    if (i == 0) begin : g_first
      assign px = x_in;
      assign py = '0;
      assign pz = z_in;
    end else begin : g_next
      assign px = x_r[i-1];
      assign py = y_r[i-1];
      assign pz = z_r[i-1];
    end
    assign at = $signed({1'b0, awc_pkg::atan_entry(i)});

    // zero residual counts as non-negative
    always_ff @(posedge clk) begin
      if (!pz[awc_pkg::ZW-1]) begin
        x_r[i] <= px - (py >>> i);
        y_r[i] <= py + (px >>> i);
        z_r[i] <= pz - at;
      end else begin
        x_r[i] <= px + (py >>> i);
        y_r[i] <= py - (px >>> i);
        z_r[i] <= pz + at;
      end
    end
  end

  assign x_out = x_r[awc_pkg::STAGES-1];
  assign y_out = y_r[awc_pkg::STAGES-1];

endmodule
`default_nettype wire

// ----- src/awc_vector.sv -----
`default_nettype none
module awc_vector (
  input  wire logic                          clk,
  input  wire logic signed [awc_pkg::XW-1:0] x_in,
  input  wire logic signed [awc_pkg::XW-1:0] y_in,
  input  wire logic        [31:0]            acc_in,
  output logic signed [awc_pkg::XW-1:0]      x_out,
  output logic        [31:0]                 acc_out
);

  logic signed [awc_pkg::XW-1:0] x_r   [awc_pkg::STAGES];
  logic signed [awc_pkg::XW-1:0] y_r   [awc_pkg::STAGES];
  logic        [31:0]            acc_r [awc_pkg::STAGES];

  for (genvar i = 0; i < awc_pkg::STAGES; i++) begin : g_stage
    logic signed [awc_pkg::XW-1:0] px;
    logic signed [awc_pkg::XW-1:0] py;
    logic        [31:0]            pa;
    if (i == 0) begin : g_first
      assign px = x_in;
      assign py = y_in;
      assign pa = acc_in;
    end else begin : g_next
      assign px = x_r[i-1];
      assign py = y_r[i-1];
      assign pa = acc_r[i-1];
    end

    // drive y toward zero, angle accumulator wraps mod full turn
    always_ff @(posedge clk) begin
      if (!py[awc_pkg::XW-1]) begin
        x_r[i]   <= px + (py >>> i);
        y_r[i]   <= py - (px >>> i);
        acc_r[i] <= pa + awc_pkg::atan_entry(i);
      end else begin
        x_r[i]   <= px - (py >>> i);
        y_r[i]   <= py + (px >>> i);
        acc_r[i] <= pa - awc_pkg::atan_entry(i);
      end
    end
  end

  assign x_out   = x_r[awc_pkg::STAGES-1];
  assign acc_out = acc_r[awc_pkg::STAGES-1];

endmodule
`default_nettype wire

// ----- src/awc_checker.sv -----
`default_nettype none
module awc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic [14:0] out_apparent_speed,
  input wire logic        cfg_ready
);

  localparam int LAT = 2 * awc_pkg::STAGES + 6;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg port not ready");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("transaction result missing");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && rst_n, LAT))
    else $error("result without transaction");

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_apparent_speed <= awc_pkg::SPEED_MAX))
    else $error("speed above saturation");

endmodule

bind apparent_wind_calculator_unit awc_checker u_awc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_apparent_speed (out_apparent_speed),
  .cfg_ready          (cfg_ready)
);
`default_nettype wire
